// ===== rtl/core/rdiv_pkg.sv =====
// shared types, constants and helper functions of the renyi divergence block
`timescale 1ns / 1ps
package rdiv_pkg;

  // default pairs per block and depth of the request queue
  localparam int unsigned BLOCK_SIZE_DEF  = 64;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // alpha of 1.0 in unsigned q4.12
  localparam logic [15:0] ALPHA_ONE = 16'd4096;
  // ln 2 in q.20
  localparam logic signed [20:0] LN2_Q20 = 21'sd726817;
  // saturation limit of the power product sum
  localparam logic [39:0] PPS_MAX = 40'hFF_FFFF_FFFF;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_SILENT     = 2'd1;
  localparam logic [1:0] ST_ALPHA_ONE  = 2'd2;
  localparam logic [1:0] ST_NO_OVERLAP = 2'd3;

  // register indexes
  localparam logic CFG_ALPHA     = 1'b0;
  localparam logic CFG_NORMALIZE = 1'b1;

  // one classified request between front and back
  typedef struct packed {
    logic               pos;
    logic               last;
    logic signed [15:0] q;
    logic signed [15:0] p;
  } item_t;

  // log2 unit request and response
  typedef struct packed {
    logic        start;
    logic [39:0] x;
  } log_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [21:0] r;
  } log_rsp_t;

  // integer square root, used only at elaboration
  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bv;
    n   = n_in;
    res = 64'd0;
    bv  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (n >= res + bv) begin
        n   = n - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  // 2^(2^-(k+1)) in q1.30, chain of truncated square roots
  function automatic logic [30:0] root_const(input int k);
    logic [63:0] r;
    r = isqrt64(64'd2 << 60);
    for (int j = 1; j < 16; j++) begin
      if (j <= k) begin
        r = isqrt64(r << 30);
      end
    end
    return r[30:0];
  endfunction

endpackage

// ===== rtl/core/rdiv_front.sv =====
// front part: takes sample pairs, counts the block and classifies each pair
`timescale 1ns / 1ps
module rdiv_front #(
  parameter int unsigned BLOCK_SIZE = rdiv_pkg::BLOCK_SIZE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  logic [31:0]         s_data_i,
  input  logic                s_last_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output rdiv_pkg::item_t     q_item_o
);
  import rdiv_pkg::*;

  localparam int unsigned CNT_W = $clog2(BLOCK_SIZE + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] cnt_inc;
  logic             close_blk;
  logic signed [15:0] p_s, q_s;

  assign p_s       = $signed(s_data_i[15:0]);
  assign q_s       = $signed(s_data_i[31:16]);
  assign s_ready_o = !q_full_i;
  assign q_push_o  = s_valid_i && !q_full_i;

  // block closes on last or on the final pair of a full block
  assign cnt_inc   = cnt_q + CNT_W'(1);
  assign close_blk = s_last_i || (cnt_inc >= CNT_W'(BLOCK_SIZE));

  always_comb begin
    q_item_o.p    = p_s;
    q_item_o.q    = q_s;
    q_item_o.last = close_blk;
    q_item_o.pos  = (p_s > 16'sd0) && (q_s > 16'sd0);
  end

  always_comb begin
    cnt_d = cnt_q;
    if (q_push_o) begin
      cnt_d = close_blk ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/rdiv_queue.sv =====
// short request queue between front and back
`timescale 1ns / 1ps
module rdiv_queue #(
  parameter int unsigned DEPTH = rdiv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rdiv_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output rdiv_pkg::item_t item_o,
  output logic            empty_o
);
  import rdiv_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_q];

  // pointer wrap and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/core/rdiv_log2.sv =====
// iterative log2 in q.16: normalize, then sixteen squaring steps
`timescale 1ns / 1ps
module rdiv_log2 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rdiv_pkg::log_req_t req_i,
  output rdiv_pkg::log_rsp_t rsp_o
);
  import rdiv_pkg::*;

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_NORM = 2'd1;
  localparam logic [1:0] L_SQR  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [39:0] xs_q, xs_d;
  logic [5:0]  e_q, e_d;
  logic [30:0] m_q, m_d;
  logic [15:0] frac_q, frac_d;
  logic [3:0]  b_q, b_d;
  logic        done_q, done_d;
  logic [61:0] sq;
  logic [31:0] sq_t;

  assign sq   = 62'(m_q) * 62'(m_q);
  assign sq_t = sq[61:30];

  always_comb begin
    state_d = state_q;
    xs_d    = xs_q;
    e_d     = e_q;
    m_d     = m_q;
    frac_d  = frac_q;
    b_d     = b_q;
    done_d  = 1'b0;
    case (state_q)
      L_IDLE: begin
        if (req_i.start) begin
          xs_d   = req_i.x;
          e_d    = 6'd39;
          frac_d = '0;
          if (req_i.x == '0) begin
            e_d    = '0;
            done_d = 1'b1;
          end else begin
            state_d = L_NORM;
          end
        end
      end
      // leading one search, a byte or a bit a cycle
      L_NORM: begin
        if (xs_q[39]) begin
          m_d     = xs_q[39:9];
          b_d     = 4'd15;
          state_d = L_SQR;
        end else if (xs_q[39:32] == '0) begin
          xs_d = {xs_q[31:0], 8'd0};
          e_d  = e_q - 6'd8;
        end else begin
          xs_d = {xs_q[38:0], 1'b0};
          e_d  = e_q - 6'd1;
        end
      end
      // one fraction bit per squaring
      L_SQR: begin
        if (sq_t[31]) begin
          m_d       = sq_t[31:1];
          frac_d[b_q] = 1'b1;
        end else begin
          m_d = sq_t[30:0];
        end
        if (b_q == '0) begin
          state_d = L_IDLE;
          done_d  = 1'b1;
        end else begin
          b_d = b_q - 4'd1;
        end
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xs_q   <= xs_d;
    e_q    <= e_d;
    m_q    <= m_d;
    frac_q <= frac_d;
    b_q    <= b_d;
  end

  always_comb begin
    rsp_o.busy = (state_q != L_IDLE);
    rsp_o.done = done_q;
    rsp_o.r    = {e_q, frac_q};
  end

endmodule

// ===== rtl/core/rdiv_back.sv =====
// back part: sums, power terms, final divergence and the output register
`timescale 1ns / 1ps
module rdiv_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        alpha_i,
  input  logic               normalize_i,
  input  logic               q_empty_i,
  input  rdiv_pkg::item_t    q_item_i,
  output logic               q_pop_o,
  output rdiv_pkg::log_req_t log_req_o,
  input  rdiv_pkg::log_rsp_t log_rsp_i,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output logic [31:0]        m_div_o,
  output logic [1:0]         m_status_o
);
  import rdiv_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_LP   = 5'd1;
  localparam logic [4:0] S_LQ   = 5'd2;
  localparam logic [4:0] S_MA   = 5'd3;
  localparam logic [4:0] S_MB   = 5'd4;
  localparam logic [4:0] S_EXP  = 5'd5;
  localparam logic [4:0] S_EACC = 5'd6;
  localparam logic [4:0] S_CHK  = 5'd7;
  localparam logic [4:0] S_LS   = 5'd8;
  localparam logic [4:0] S_LSP  = 5'd9;
  localparam logic [4:0] S_LSQ  = 5'd10;
  localparam logic [4:0] S_NSUB = 5'd11;
  localparam logic [4:0] S_MUL  = 5'd12;
  localparam logic [4:0] S_DIVS = 5'd13;
  localparam logic [4:0] S_DIV  = 5'd14;
  localparam logic [4:0] S_FIN  = 5'd15;
  localparam logic [4:0] S_OUT  = 5'd16;

  localparam int unsigned DIV_W = 43;
  localparam logic signed [22:0] LOG_OFS15 = 23'sd983040;
  localparam logic signed [22:0] LOG_OFS16 = 23'sd1048576;

  logic [4:0]          state_q, state_d;
  item_t               item_q, item_d;
  logic signed [23:0]  sum_p_q, sum_p_d, sum_q_q, sum_q_d;
  logic [39:0]         pps_q, pps_d;
  logic signed [22:0]  l1_q, l1_d, l2_q, l2_d, n16_q, n16_d;
  logic signed [39:0]  prod_a_q, prod_a_d;
  logic signed [40:0]  y_q, y_d;
  logic                fin_q, fin_d;
  logic [30:0]         m_q, m_d;
  logic [3:0]          k_q, k_d;
  logic signed [41:0]  n28_q, n28_d;
  logic signed [62:0]  prod_q, prod_d;
  logic [DIV_W-1:0]    dvd_q, dvd_d;
  logic [15:0]         rem_q, rem_d;
  logic [5:0]          dcnt_q, dcnt_d;
  logic                neg_q, neg_d;
  logic [31:0]         res_div_q, res_div_d;
  logic [1:0]          res_st_q, res_st_d;
  logic                out_valid_q, out_valid_d;
  logic [31:0]         out_div_q, out_div_d;
  logic [1:0]          out_st_q, out_st_d;

  logic [30:0]         root_tab [16];
  logic signed [16:0]  a_s, ia_s;
  logic [15:0]         dmag;
  logic signed [22:0]  log_val;
  logic [61:0]         eprod;
  logic signed [12:0]  exp_i;
  logic signed [13:0]  shr;
  logic [39:0]         term;
  logic [40:0]         pps_sum;
  logic [62:0]         prod_mag;
  logic [16:0]         rsh;
  logic                out_free;

  // root constants, fixed at elaboration
  for (genvar g = 0; g < 16; g++) begin : g_root
    localparam logic [30:0] RootVal = root_const(g);
    assign root_tab[g] = RootVal;
  end

  function automatic logic signed [23:0] sat24(input logic signed [23:0] a,
                                               input logic signed [15:0] b);
    logic signed [24:0] s;
    s = 25'(a) + 25'(b);
    if (s > 25'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (s < -25'sd8388608) begin
      return 24'sh800000;
    end
    return s[23:0];
  endfunction

  assign a_s      = $signed({1'b0, alpha_i});
  assign ia_s     = $signed(17'd4096) - a_s;
  assign dmag     = (alpha_i > ALPHA_ONE) ? (alpha_i - ALPHA_ONE) : (ALPHA_ONE - alpha_i);
  assign log_val  = $signed({1'b0, log_rsp_i.r});
  assign eprod    = 62'(m_q) * 62'(root_tab[k_q]);
  assign exp_i    = y_q[40:28];
  assign shr      = 14'sd23 - 14'(exp_i);
  assign out_free = !out_valid_q || m_ready_i;
  assign prod_mag = prod_q[62] ? 63'(-prod_q) : 63'(prod_q);
  assign rsh      = {rem_q, dvd_q[DIV_W-1]};

  // exp2 scaling of the mantissa into q24.16
  always_comb begin
    if (exp_i >= 13'sd24) begin
      term = PPS_MAX;
    end else if (shr > 14'sd39) begin
      term = '0;
    end else begin
      term = {m_q, 9'd0} >> shr[5:0];
    end
    pps_sum = {1'b0, pps_q} + {1'b0, term};
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    sum_p_d     = sum_p_q;
    sum_q_d     = sum_q_q;
    pps_d       = pps_q;
    l1_d        = l1_q;
    l2_d        = l2_q;
    n16_d       = n16_q;
    prod_a_d    = prod_a_q;
    y_d         = y_q;
    fin_d       = fin_q;
    m_d         = m_q;
    k_d         = k_q;
    n28_d       = n28_q;
    prod_d      = prod_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    dcnt_d      = dcnt_q;
    neg_d       = neg_q;
    res_div_d   = res_div_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && !m_ready_i;
    out_div_d   = out_div_q;
    out_st_d    = out_st_q;
    q_pop_o     = 1'b0;
    log_req_o.start = 1'b0;
    log_req_o.x     = '0;
    case (state_q)
      // take a request and update the running sums
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          sum_p_d = sat24(sum_p_q, q_item_i.p);
          sum_q_d = sat24(sum_q_q, q_item_i.q);
          fin_d   = 1'b0;
          if (q_item_i.pos) begin
            log_req_o.start = 1'b1;
            log_req_o.x     = {24'd0, q_item_i.p};
            state_d         = S_LP;
          end else begin
            state_d = S_CHK;
          end
        end
      end
      S_LP: begin
        if (log_rsp_i.done) begin
          l1_d            = log_val - LOG_OFS15;
          log_req_o.start = 1'b1;
          log_req_o.x     = {24'd0, item_q.q};
          state_d         = S_LQ;
        end
      end
      S_LQ: begin
        if (log_rsp_i.done) begin
          l2_d    = log_val - LOG_OFS15;
          state_d = S_MA;
        end
      end
      // weighted exponent alpha*l1 + (1-alpha)*l2 in q.28
      S_MA: begin
        prod_a_d = 40'(a_s) * 40'(l1_q);
        state_d  = S_MB;
      end
      S_MB: begin
        y_d = 41'(prod_a_q) + 41'(ia_s) * 41'(l2_q);
        if (fin_q) begin
          state_d = S_NSUB;
        end else begin
          m_d     = 31'd1 << 30;
          k_d     = '0;
          state_d = S_EXP;
        end
      end
      // fraction of exp2, one root factor a cycle
      S_EXP: begin
        if (y_q[5'd27 - 5'(k_q)]) begin
          m_d = eprod[60:30];
        end
        if (k_q == 4'd15) begin
          state_d = S_EACC;
        end else begin
          k_d = k_q + 4'd1;
        end
      end
      S_EACC: begin
        pps_d   = pps_sum[40] ? PPS_MAX : pps_sum[39:0];
        state_d = S_CHK;
      end
      // mid-block back to idle; at end of block: special cases or the full measure
      S_CHK: begin
        if (!item_q.last) begin
          state_d = S_IDLE;
        end else if (sum_p_q <= 24'sd0 || sum_q_q <= 24'sd0) begin
          res_st_d  = ST_SILENT;
          res_div_d = '0;
          state_d   = S_OUT;
        end else if (alpha_i == ALPHA_ONE) begin
          res_st_d  = ST_ALPHA_ONE;
          res_div_d = '0;
          state_d   = S_OUT;
        end else if (pps_q == '0) begin
          res_st_d  = ST_NO_OVERLAP;
          res_div_d = (alpha_i > ALPHA_ONE) ? 32'h8000_0000 : 32'h7FFF_FFFF;
          state_d   = S_OUT;
        end else begin
          log_req_o.start = 1'b1;
          log_req_o.x     = pps_q;
          state_d         = S_LS;
        end
      end
      S_LS: begin
        if (log_rsp_i.done) begin
          n16_d = log_val - LOG_OFS16;
          if (normalize_i) begin
            fin_d           = 1'b1;
            log_req_o.start = 1'b1;
            log_req_o.x     = {16'd0, sum_p_q};
            state_d         = S_LSP;
          end else begin
            n28_d   = {{7{n16_d[22]}}, n16_d, 12'd0};
            state_d = S_MUL;
          end
        end
      end
      S_LSP: begin
        if (log_rsp_i.done) begin
          l1_d            = log_val - LOG_OFS15;
          log_req_o.start = 1'b1;
          log_req_o.x     = {16'd0, sum_q_q};
          state_d         = S_LSQ;
        end
      end
      S_LSQ: begin
        if (log_rsp_i.done) begin
          l2_d    = log_val - LOG_OFS15;
          state_d = S_MA;
        end
      end
      S_NSUB: begin
        n28_d   = {{7{n16_q[22]}}, n16_q, 12'd0} - 42'(y_q);
        state_d = S_MUL;
      end
      S_MUL: begin
        prod_d  = 63'(n28_q) * 63'(LN2_Q20);
        state_d = S_DIVS;
      end
      // magnitude division by |alpha-1| after dropping the 2^20 scale
      S_DIVS: begin
        dvd_d   = prod_mag[62:20];
        rem_d   = '0;
        dcnt_d  = 6'(DIV_W);
        neg_d   = prod_q[62] ^ (alpha_i < ALPHA_ONE);
        state_d = S_DIV;
      end
      S_DIV: begin
        if (rsh >= {1'b0, dmag}) begin
          rem_d = 16'(rsh - {1'b0, dmag});
          dvd_d = {dvd_q[DIV_W-2:0], 1'b1};
        end else begin
          rem_d = rsh[15:0];
          dvd_d = {dvd_q[DIV_W-2:0], 1'b0};
        end
        dcnt_d = dcnt_q - 6'd1;
        if (dcnt_q == 6'd1) begin
          state_d = S_FIN;
        end
      end
      // sign and saturation
      S_FIN: begin
        res_st_d = ST_OK;
        if (neg_q) begin
          res_div_d = (dvd_q > DIV_W'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
                                                          : 32'(-dvd_q[31:0]);
        end else begin
          res_div_d = (dvd_q > DIV_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : dvd_q[31:0];
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_div_d   = res_div_q;
          out_st_d    = res_st_q;
          sum_p_d     = '0;
          sum_q_d     = '0;
          pps_d       = '0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_p_q     <= '0;
      sum_q_q     <= '0;
      pps_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_p_q     <= sum_p_d;
      sum_q_q     <= sum_q_d;
      pps_q       <= pps_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    l1_q      <= l1_d;
    l2_q      <= l2_d;
    n16_q     <= n16_d;
    prod_a_q  <= prod_a_d;
    y_q       <= y_d;
    fin_q     <= fin_d;
    m_q       <= m_d;
    k_q       <= k_d;
    n28_q     <= n28_d;
    prod_q    <= prod_d;
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    dcnt_q    <= dcnt_d;
    neg_q     <= neg_d;
    res_div_q <= res_div_d;
    res_st_q  <= res_st_d;
    out_div_q <= out_div_d;
    out_st_q  <= out_st_d;
  end

  assign m_valid_o  = out_valid_q;
  assign m_div_o    = out_div_q;
  assign m_status_o = out_st_q;

  // log unit is never restarted while it works
  a_log_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    log_req_o.start |-> !log_rsp_i.busy)
    else $error("log2 start while busy");

  // a finished result always lands in the output register
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("result not loaded");

  // silent and alpha-one statuses carry a zero value
  a_zero_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_st_q == ST_SILENT || out_st_q == ST_ALPHA_ONE))
      |-> (out_div_q == '0))
    else $error("nonzero value on silent or alpha one");

  // sums are empty again after a result
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free) |=> (pps_q == '0 && sum_p_q == '0))
    else $error("block state not cleared");

endmodule

// ===== rtl/core/renyi_divergence.sv =====
// top level of the streaming renyi divergence block
//
// usage: sample pairs enter on the s_axis channel, p in tdata[15:0] and q in
// tdata[31:16], both signed q1.15, tlast on the closing pair of a block. a
// block also closes on its BLOCK_SIZE-th pair. one result leaves on m_axis
// per block: tdata is the divergence in signed q16.16, tuser the status
// (ok, silent input, alpha equals one, no overlap).
// alpha (q4.12) and normalize are set through the write port between blocks.
// per pair: one with both samples positive needs two log2 runs, the
// weighted exponent multiply and 16 exp2 steps; other pairs only update
// the sums. the closing pair adds one log2 run, or three with normalize,
// a multiply and a bit-serial divide; a special status skips these steps.
// all log2 runs share the one log2 unit, which the back sequencer drives.
// a queue of QUEUE_DEPTH pairs sits between intake and compute, so input is
// taken while the back is busy or a result waits. a stalled receiver holds
// the result register and, once the queue fills, s_axis_tready drops.
// reset clears sums, counters and queue and sets alpha to 1.0, normalize off.
`timescale 1ns / 1ps
module renyi_divergence #(
  parameter int unsigned BLOCK_SIZE  = rdiv_pkg::BLOCK_SIZE_DEF,
  parameter int unsigned QUEUE_DEPTH = rdiv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // p_sample [15:0], q_sample [31:16]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // divergence [31:0]
  output logic [1:0]  m_axis_tuser,   // status [1:0]
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import rdiv_pkg::*;

  logic [15:0] alpha_q, alpha_d;
  logic        normalize_q, normalize_d;
  logic        q_full, q_empty, q_push, q_pop;
  item_t       push_item, pop_item;
  log_req_t    log_req;
  log_rsp_t    log_rsp;

  // configuration registers
  always_comb begin
    alpha_d     = alpha_q;
    normalize_d = normalize_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ALPHA:     alpha_d     = cfg_data_i;
        CFG_NORMALIZE: normalize_d = cfg_data_i[0];
        default:       alpha_d     = alpha_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q     <= ALPHA_ONE;
      normalize_q <= 1'b0;
    end else begin
      alpha_q     <= alpha_d;
      normalize_q <= normalize_d;
    end
  end

  rdiv_front #(.BLOCK_SIZE(BLOCK_SIZE)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_last_i  (s_axis_tlast),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_item_o  (push_item)
  );

  rdiv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (pop_item),
    .empty_o (q_empty)
  );

  rdiv_log2 u_log2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (log_req),
    .rsp_o  (log_rsp)
  );

  rdiv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .alpha_i     (alpha_q),
    .normalize_i (normalize_q),
    .q_empty_i   (q_empty),
    .q_item_i    (pop_item),
    .q_pop_o     (q_pop),
    .log_req_o   (log_req),
    .log_rsp_i   (log_rsp),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_div_o     (m_axis_tdata),
    .m_status_o  (m_axis_tuser)
  );

endmodule

// ===== bench/renyi_divergence_test.sv =====
// self-checking testbench of the streaming renyi divergence block
`timescale 1ns / 1ps
module renyi_divergence_test;
  import rdiv_pkg::*;

  localparam int unsigned PAIRS_PER_BLOCK = 64;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES = 600;
  localparam int unsigned LONG_HOLD = 400;

  typedef struct packed {
    logic [31:0] div;
    logic [1:0]  st;
  } verdict_t;

  typedef enum logic {ROW_PAIR, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic               idx;
    logic [15:0]        val;
    logic signed [15:0] p;
    logic signed [15:0] q;
    logic               last;
    logic               typed;
    logic [31:0]        div;
    logic [1:0]         st;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  renyi_divergence dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  // clock, period 20 ns
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor copy of registers and block state
  logic [15:0]        alpha_q412;
  logic               norm_on;
  int                 acc_p;
  int                 acc_q;
  longint unsigned    overlap_sum;
  int                 pairs_taken;
  longint unsigned    half_roots [16];

  verdict_t divergence_q[$];
  int unsigned mismatches = 0;
  int unsigned pairs_sent = 0;
  int unsigned results_seen = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};
  int unsigned quiet_cycles = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit hold_off_req = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bv;
    res = 0;
    bv = 64'd1 << 62;
    while (bv > n) bv = bv >> 2;
    while (bv != 0) begin
      if (n >= res + bv) begin
        n = n - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  // log2 in q.16 by repeated squaring of a q1.30 mantissa
  function automatic longint log2_fix(longint unsigned x);
    int e;
    longint unsigned m;
    longint r;
    if (x == 0) return 0;
    e = 63;
    while (!x[e]) e--;
    m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
    r = longint'(e) * 65536;
    for (int b = 15; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        r = r + (longint'(1) << b);
      end
    end
    return r;
  endfunction

  function automatic longint div_floor(longint y, longint d);
    if (y >= 0) return y / d;
    return -((-y + d - 1) / d);
  endfunction

  // 2^y, y in q.16, to q24.16 saturated at 40 bits
  function automatic longint unsigned pow2_fix(longint y);
    longint i;
    longint f;
    longint sh;
    longint unsigned m;
    i = div_floor(y, 65536);
    f = y - i * 65536;
    m = 64'd1 << 30;
    for (int k = 0; k < 16; k++)
      if (f[15 - k]) m = (m * half_roots[k]) >> 30;
    if (i >= 24) return PPS_MAX;
    sh = 14 - i;
    if (sh >= 63) return 0;
    if (sh >= 0) return m >> sh;
    return m << (-sh);
  endfunction

  function automatic int add_sat24(int a, int b);
    int s;
    s = a + b;
    if (s > 8388607) return 8388607;
    if (s < -8388608) return -8388608;
    return s;
  endfunction

  // advance the block state by one pair, return 1 when a result is due
  function automatic bit predict_pair(logic signed [15:0] p, logic signed [15:0] q,
                                      logic last_in, output verdict_t v);
    longint a;
    longint lp;
    longint lq;
    longint n28;
    longint val;
    logic [1:0] st;
    bit closing;
    a = longint'(alpha_q412);
    val = 0;
    st = ST_OK;
    acc_p = add_sat24(acc_p, int'(p));
    acc_q = add_sat24(acc_q, int'(q));
    if (p > 0 && q > 0) begin
      lp = log2_fix(longint'(p)) - 15 * 65536;
      lq = log2_fix(longint'(q)) - 15 * 65536;
      overlap_sum = overlap_sum + pow2_fix(div_floor(a * lp + (4096 - a) * lq, 4096));
      if (overlap_sum > PPS_MAX) overlap_sum = PPS_MAX;
    end
    pairs_taken++;
    closing = last_in || (pairs_taken >= PAIRS_PER_BLOCK);
    if (!closing) return 1'b0;
    if (acc_p <= 0 || acc_q <= 0) begin
      st = ST_SILENT;
    end else if (alpha_q412 == ALPHA_ONE) begin
      st = ST_ALPHA_ONE;
    end else if (overlap_sum == 0) begin
      st = ST_NO_OVERLAP;
      val = (a > 4096) ? -64'sd2147483648 : 64'sd2147483647;
    end else begin
      n28 = (log2_fix(overlap_sum) - 16 * 65536) * 4096;
      if (norm_on) begin
        lp = log2_fix(longint'(acc_p)) - 15 * 65536;
        lq = log2_fix(longint'(acc_q)) - 15 * 65536;
        n28 = n28 - (a * lp + (4096 - a) * lq);
      end
      val = (n28 * 726817) / ((a - 4096) * (longint'(1) << 20));
      if (val > 2147483647) val = 2147483647;
      if (val < -64'sd2147483648) val = -64'sd2147483648;
    end
    v.div = val[31:0];
    v.st = st;
    acc_p = 0;
    acc_q = 0;
    overlap_sum = 0;
    pairs_taken = 0;
    return 1'b1;
  endfunction

  // offer one pair and wait for it to be taken
  task automatic send_pair(logic signed [15:0] p, logic signed [15:0] q, logic last_in,
                           logic typed, logic [31:0] tdiv, logic [1:0] tst);
    int gap;
    verdict_t v;
    gap = tx_steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata <= {q, p};
    s_axis_tlast <= last_in;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pairs_sent++;
    if (predict_pair(p, q, last_in, v)) begin
      if (typed) begin
        v.div = tdiv;
        v.st = tst;
      end
      divergence_q.push_back(v);
    end
    @(negedge clk_i);
  endtask

  // let every request drain before touching registers
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    while (divergence_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_ALPHA) alpha_q412 = val;
    else norm_on = val[0];
  endtask

  function automatic logic signed [15:0] draw_sample(bit noisy);
    case ($urandom_range(0, noisy ? 5 : 11))
      0: return 16'(32767);
      1: return 16'(1);
      2, 3: return 16'($urandom_range(0, 65535));
      4: return 16'(-32768);
      5: return 16'(0);
      6, 7: return 16'($urandom_range(1, 255));
      default: return 16'($urandom_range(1, 32767));
    endcase
  endfunction

  // result side: random stalls, compare against oldest expectation
  initial begin
    verdict_t exp_v;
    int gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off_req) begin
        gap = LONG_HOLD;
        hold_off_req = 1'b0;
      end else begin
        gap = rx_steady ? 0 : $urandom_range(0, 12);
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      results_seen++;
      status_seen[m_axis_tuser]++;
      if (divergence_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result div=%h status=%0d", m_axis_tdata, m_axis_tuser);
      end else begin
        exp_v = divergence_q.pop_front();
        if (exp_v.div !== m_axis_tdata || exp_v.st !== m_axis_tuser) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected div=%h status=%0d, got div=%h status=%0d",
                     results_seen, exp_v.div, exp_v.st, m_axis_tdata, m_axis_tuser);
        end
      end
      @(negedge clk_i);
    end
  end

  // watchdog on cycles without any request moving
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    row_t rows [$];
    row_t r;
    int blk_len;
    bit noisy;
    logic [15:0] a_pick;
    half_roots[0] = int_sqrt(64'd2 << 60);
    for (int k = 1; k < 16; k++) half_roots[k] = int_sqrt(half_roots[k - 1] << 30);
    alpha_q412 = ALPHA_ONE;
    norm_on = 1'b0;
    acc_p = 0;
    acc_q = 0;
    overlap_sum = 0;
    pairs_taken = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed rows; typed where the outcome is plain
    rows = '{
      '{ROW_PAIR, 1'b0, 16'd0, 16'sd16384, 16'sd16384, 1'b1, 1'b1, 32'd0, ST_ALPHA_ONE},
      '{ROW_PAIR, 1'b0, 16'd0, 16'sd0, 16'sd0, 1'b1, 1'b1, 32'd0, ST_SILENT},
      '{ROW_PAIR, 1'b0, 16'd0, -16'sd32768, 16'sd32767, 1'b1, 1'b1, 32'd0, ST_SILENT},
      '{ROW_PAIR, 1'b0, 16'd0, 16'sd32767, -16'sd32768, 1'b1, 1'b1, 32'd0, ST_SILENT},
      '{ROW_CFG, CFG_ALPHA, 16'd8192, 16'sd0, 16'sd0, 1'b0, 1'b0, 32'd0, ST_OK},
      '{ROW_PAIR, 1'b0, 16'd0, 16'sd16384, -16'sd1, 1'b0, 1'b0, 32'd0, ST_OK},
      '{ROW_PAIR, 1'b0, 16'd0, -16'sd1, 16'sd16384, 1'b1, 1'b1, 32'h8000_0000, ST_NO_OVERLAP},
      '{ROW_CFG, CFG_ALPHA, 16'd2048, 16'sd0, 16'sd0, 1'b0, 1'b0, 32'd0, ST_OK},
      '{ROW_PAIR, 1'b0, 16'd0, 16'sd16384, -16'sd1, 1'b0, 1'b0, 32'd0, ST_OK},
      '{ROW_PAIR, 1'b0, 16'd0, -16'sd1, 16'sd16384, 1'b1, 1'b1, 32'h7FFF_FFFF, ST_NO_OVERLAP},
      '{ROW_PAIR, 1'b0, 16'd0, 16'sd8192, 16'sd24576, 1'b0, 1'b0, 32'd0, ST_OK},
      '{ROW_PAIR, 1'b0, 16'd0, 16'sd24576, 16'sd8192, 1'b1, 1'b0, 32'd0, ST_OK},
      '{ROW_CFG, CFG_ALPHA, 16'd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 32'd0, ST_OK},
      '{ROW_PAIR, 1'b0, 16'd0, 16'sd32767, 16'sd1, 1'b1, 1'b0, 32'd0, ST_OK},
      '{ROW_CFG, CFG_ALPHA, 16'd65535, 16'sd0, 16'sd0, 1'b0, 1'b0, 32'd0, ST_OK},
      '{ROW_CFG, CFG_NORMALIZE, 16'd1, 16'sd0, 16'sd0, 1'b0, 1'b0, 32'd0, ST_OK},
      '{ROW_PAIR, 1'b0, 16'd0, 16'sd1, 16'sd32767, 1'b0, 1'b0, 32'd0, ST_OK},
      '{ROW_PAIR, 1'b0, 16'd0, 16'sd32767, 16'sd32767, 1'b1, 1'b0, 32'd0, ST_OK},
      '{ROW_CFG, CFG_ALPHA, 16'd4097, 16'sd0, 16'sd0, 1'b0, 1'b0, 32'd0, ST_OK},
      '{ROW_PAIR, 1'b0, 16'd0, 16'sd100, 16'sd30000, 1'b1, 1'b0, 32'd0, ST_OK}
    };
    foreach (rows[i]) begin
      r = rows[i];
      if (r.kind == ROW_CFG) begin
        drain_block();
        write_reg(r.idx, r.val);
      end else begin
        send_pair(r.p, r.q, r.last, r.typed, r.div, r.st);
      end
    end

    // long block closed by the pair count alone
    for (int i = 0; i < PAIRS_PER_BLOCK; i++)
      send_pair(16'sd32767, 16'sd32767, 1'b0, 1'b0, 32'd0, ST_OK);

    // random phases, each with its own register setting
    for (int ph = 0; pairs_sent < 1300; ph++) begin
      drain_block();
      case (ph % 6)
        0: a_pick = 16'd0;
        1: a_pick = 16'd65535;
        2: a_pick = ALPHA_ONE;
        3: a_pick = 16'd4095;
        default: a_pick = 16'($urandom_range(0, 65535));
      endcase
      write_reg(CFG_ALPHA, a_pick);
      write_reg(CFG_NORMALIZE, 16'($urandom_range(0, 1)));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if (ph == 2) begin
        // receiver holds off while short blocks pile up
        hold_off_req = 1'b1;
        tx_steady = 1'b1;
      end
      for (int b = 0; b < 8; b++) begin
        blk_len = ($urandom_range(0, 15) == 0) ? 70 : $urandom_range(1, 12);
        if (ph == 2) blk_len = 1;
        noisy = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < blk_len; i++)
          send_pair(draw_sample(noisy), draw_sample(noisy),
                    (i == blk_len - 1) && ($urandom_range(0, 9) != 0),
                    1'b0, 32'd0, ST_OK);
      end
    end

    // flush any open block, then wait out the tail
    send_pair(16'sd1000, 16'sd2000, 1'b1, 1'b0, 32'd0, ST_OK);
    drain_block();
    if (divergence_q.size() != 0) mismatches++;
    $display("sent %0d pairs, checked %0d results", pairs_sent, results_seen);
    $display("status ok %0d, silent %0d, alpha one %0d, no overlap %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rdiv_pkg.sv
rtl/core/rdiv_front.sv
rtl/core/rdiv_queue.sv
rtl/core/rdiv_log2.sv
rtl/core/rdiv_back.sv
rtl/core/renyi_divergence.sv
bench/renyi_divergence_test.sv
